// ===== src/cdpc_pkg.sv =====
package cdpc_pkg;

	// Field and datapath widths
	localparam int FRAC_BITS = 20;
	localparam int R_STEPS   = 8;
	localparam int FOUT_W    = 25;
	localparam int REF_W     = 27;
	localparam int VCO_W     = 30;
	localparam int FB_W      = FRAC_BITS + 1;
	localparam int QW        = VCO_W + FB_W;
	localparam int CNT_W     = $clog2(QW + 1);
	localparam int CMP_W     = REF_W + 7;
	localparam int P1_SHIFT  = 7;

	localparam int MS_P1_W   = 18;
	localparam int MS_P2_W   = 20;
	localparam int P3_W      = 21;
	localparam int R_W       = 3;
	localparam int PLL_P1_W  = 14;
	localparam int PLL_P2_W  = 20;
	localparam int STAT_W    = 2;

	// Limits
	localparam logic [VCO_W-1:0]  VCO_MIN   = VCO_W'(700000000);
	localparam logic [FOUT_W-1:0] FOUT_MAX  = FOUT_W'(20000000);
	localparam logic [REF_W-1:0]  REF_RESET = REF_W'(30720000);
	localparam int MS_LOW     = 6;
	localparam int MS_HIGH    = 1800;
	localparam int RATIO_LOW  = 15;
	localparam int RATIO_HIGH = 90;
	localparam int P1_OFFSET  = 512;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FREQ  = 2'd1,
		ST_NO_R  = 2'd2,
		ST_RATIO = 2'd3
	} status_t;

	typedef struct packed {
		logic load_in;
		logic div_start;
		logic div_pll;
		logic cap_mult;
		logic cap_fvco;
		logic cap_chk;
		logic cap_words;
		logic red_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic freq_bad;
		logic r_fit;
		logic ratio_bad;
		logic div_done;
		logic red_done;
	} sts_t;

endpackage

// ===== src/clock_divider_parameter_calc_core.sv =====
// Channel  Handshake            Payload
// cfg      cfg_valid/cfg_ready  ref_freq
// in       in_valid/in_stall    fout
// out      out_valid/out_stall  ms_p1 ms_p2 ms_p3 r_code pll_p1 pll_p2 pll_p3 status
//
// One transaction at a time; a bad fout skips the divider and goes straight to the result.
// A full run uses the shared bit-serial divider twice, first for the
// multiplier and then for the PLL ratio with its fraction, and then strips
// trailing zeros from the fractions.
// arst_n clears the sequencer and output valid and sets ref_freq to 30720000.
// The result waits in the output register under out_stall while the next
// transaction is already being taken in.
module clock_divider_parameter_calc_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [cdpc_pkg::REF_W-1:0]        ref_freq,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [cdpc_pkg::FOUT_W-1:0]       fout,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [cdpc_pkg::MS_P1_W-1:0]      ms_p1,
	output logic [cdpc_pkg::MS_P2_W-1:0]      ms_p2,
	output logic [cdpc_pkg::P3_W-1:0]         ms_p3,
	output logic [cdpc_pkg::R_W-1:0]          r_code,
	output logic [cdpc_pkg::PLL_P1_W-1:0]     pll_p1,
	output logic [cdpc_pkg::PLL_P2_W-1:0]     pll_p2,
	output logic [cdpc_pkg::P3_W-1:0]         pll_p3,
	output logic [cdpc_pkg::STAT_W-1:0]       status
);

	cdpc_pkg::cmd_t cmd;
	cdpc_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	cdpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	cdpc_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (ref_freq),
		.fout_in  (fout),
		.cmd      (cmd),
		.sts      (sts),
		.ms_p1    (ms_p1),
		.ms_p2    (ms_p2),
		.ms_p3    (ms_p3),
		.r_code   (r_code),
		.pll_p1   (pll_p1),
		.pll_p2   (pll_p2),
		.pll_p3   (pll_p3),
		.status   (status)
	);

endmodule

// ===== src/cdpc_div.sv =====
// Restoring divider, one quotient bit per cycle. Zeros are shifted in after
// the dividend is used up, so extra iterations produce fraction bits.
module cdpc_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [cdpc_pkg::VCO_W-1:0]      dividend,
	input  logic [cdpc_pkg::REF_W-1:0]      divisor,
	input  logic [cdpc_pkg::CNT_W-1:0]      iters,
	output logic                            done,
	output logic [cdpc_pkg::QW-1:0]         quo
);

	logic                           busy_q;
	logic                           done_q;
	logic [cdpc_pkg::CNT_W-1:0]     cnt_q;
	logic [cdpc_pkg::REF_W-1:0]     rem_q;
	logic [cdpc_pkg::REF_W-1:0]     dvs_q;
	logic [cdpc_pkg::VCO_W-1:0]     dvd_q;
	logic [cdpc_pkg::QW-1:0]        quo_q;

	logic [cdpc_pkg::REF_W:0]       trial;
	logic [cdpc_pkg::REF_W:0]       diff;
	logic                           ge;
	logic [cdpc_pkg::REF_W-1:0]     rem_nxt;

	always_comb begin
		trial   = {rem_q, dvd_q[cdpc_pkg::VCO_W-1]};
		ge      = trial >= {1'b0, dvs_q};
		diff    = trial - {1'b0, dvs_q};
		rem_nxt = ge ? diff[cdpc_pkg::REF_W-1:0] : trial[cdpc_pkg::REF_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == cdpc_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			dvd_q <= {dvd_q[cdpc_pkg::VCO_W-2:0], 1'b0};
			quo_q <= {quo_q[cdpc_pkg::QW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rem_q < dvs_q)
		else $error("divider remainder not below divisor");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q && $past(busy_q))
		else $error("divider done without a finishing step");

	a_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != '0)
		else $error("divider busy with empty count");

endmodule

// ===== src/cdpc_dp.sv =====
module cdpc_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [cdpc_pkg::REF_W-1:0]        cfg_data,
	input  logic [cdpc_pkg::FOUT_W-1:0]       fout_in,
	input  cdpc_pkg::cmd_t                    cmd,
	output cdpc_pkg::sts_t                    sts,
	output logic [cdpc_pkg::MS_P1_W-1:0]      ms_p1,
	output logic [cdpc_pkg::MS_P2_W-1:0]      ms_p2,
	output logic [cdpc_pkg::P3_W-1:0]         ms_p3,
	output logic [cdpc_pkg::R_W-1:0]          r_code,
	output logic [cdpc_pkg::PLL_P1_W-1:0]     pll_p1,
	output logic [cdpc_pkg::PLL_P2_W-1:0]     pll_p2,
	output logic [cdpc_pkg::P3_W-1:0]         pll_p3,
	output logic [cdpc_pkg::STAT_W-1:0]       status
);

	localparam int FW = cdpc_pkg::FRAC_BITS;
	localparam int WW = cdpc_pkg::VCO_W + cdpc_pkg::FRAC_BITS;
	localparam int PW = cdpc_pkg::FOUT_W + cdpc_pkg::VCO_W;

	logic [cdpc_pkg::REF_W-1:0]     ref_q;
	logic [cdpc_pkg::FOUT_W-1:0]    fout_q;
	logic [cdpc_pkg::VCO_W-1:0]     mult_q;
	logic [cdpc_pkg::VCO_W-1:0]     fvco_q;
	logic [cdpc_pkg::R_W-1:0]       r_q;
	logic                           r_fit_q;
	logic                           ratio_bad_q;

	logic [cdpc_pkg::FB_W-1:0]      ms_b_q, ms_c_q, pll_b_q, pll_c_q;
	logic [FW-1:0]                  ms_p2_q, pll_p2_q;
	logic [cdpc_pkg::MS_P1_W-1:0]   ms_p1_q;
	logic [cdpc_pkg::PLL_P1_W-1:0]  pll_p1_q;

	logic [cdpc_pkg::MS_P1_W-1:0]   out_ms_p1_q;
	logic [cdpc_pkg::MS_P2_W-1:0]   out_ms_p2_q;
	logic [cdpc_pkg::P3_W-1:0]      out_ms_p3_q;
	logic [cdpc_pkg::R_W-1:0]       out_r_q;
	logic [cdpc_pkg::PLL_P1_W-1:0]  out_pll_p1_q;
	logic [cdpc_pkg::PLL_P2_W-1:0]  out_pll_p2_q;
	logic [cdpc_pkg::P3_W-1:0]      out_pll_p3_q;
	cdpc_pkg::status_t              out_status_q;

	logic                           freq_bad;
	logic                           div_done;
	logic [cdpc_pkg::QW-1:0]        div_quo;
	logic [cdpc_pkg::VCO_W-1:0]     div_dvd;
	logic [cdpc_pkg::REF_W-1:0]     div_dvs;
	logic [cdpc_pkg::CNT_W-1:0]     div_iters;

	logic [PW-1:0]                  prod;
	logic                           r_fit;
	logic [cdpc_pkg::R_W-1:0]       r_sel;
	logic [cdpc_pkg::CMP_W-1:0]     ref_lo, ref_hi, fvco_x;
	logic                           ratio_bad;

	logic [WW-1:0]                  ms_wide;
	logic [cdpc_pkg::VCO_W-1:0]     ms_a, pll_a;
	logic [cdpc_pkg::FB_W-1:0]      ms_b0, pll_b0;
	logic [cdpc_pkg::FB_W:0]        pll_q1;
	logic [cdpc_pkg::MS_P1_W-1:0]   ms_p1_n;
	logic [cdpc_pkg::PLL_P1_W-1:0]  pll_p1_n;
	logic                           ms_red, pll_red;
	cdpc_pkg::status_t              status_n;

	// Config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q <= cdpc_pkg::REF_RESET;
		end else if (cfg_we) begin
			ref_q <= cfg_data;
		end
	end

	assign freq_bad = (fout_q == '0) || (fout_q > cdpc_pkg::FOUT_MAX);

	// Shared divider: multiplier first (700 MHz / fout), then fvco / ref
	// with FB_W fraction bits appended.
	always_comb begin
		div_dvd   = cmd.div_pll ? fvco_q : cdpc_pkg::VCO_MIN;
		div_dvs   = cmd.div_pll ? ref_q : cdpc_pkg::REF_W'(fout_q);
		div_iters = cmd.div_pll ? cdpc_pkg::CNT_W'(cdpc_pkg::QW)
		                        : cdpc_pkg::CNT_W'(cdpc_pkg::VCO_W);
	end

	cdpc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.iters    (div_iters),
		.done     (div_done),
		.quo      (div_quo)
	);

	assign prod = PW'(fout_q) * PW'(mult_q);

	// First R that puts the output divider strictly inside its window
	always_comb begin
		r_fit = 1'b0;
		r_sel = '0;
		for (int i = cdpc_pkg::R_STEPS - 1; i >= 0; i--) begin
			if (mult_q > cdpc_pkg::VCO_W'(cdpc_pkg::MS_LOW << i) &&
			    mult_q < cdpc_pkg::VCO_W'(cdpc_pkg::MS_HIGH << i)) begin
				r_fit = 1'b1;
				r_sel = cdpc_pkg::R_W'(i);
			end
		end
	end

	always_comb begin
		ref_lo    = cdpc_pkg::CMP_W'(ref_q) * cdpc_pkg::CMP_W'(cdpc_pkg::RATIO_LOW);
		ref_hi    = cdpc_pkg::CMP_W'(ref_q) * cdpc_pkg::CMP_W'(cdpc_pkg::RATIO_HIGH);
		fvco_x    = cdpc_pkg::CMP_W'(fvco_q);
		ratio_bad = (ref_q == '0) || (fvco_x < ref_lo) || (fvco_x > ref_hi);
	end

	// Unreduced splits. P1 is the same before and after the reduction,
	// P2 of the reduced pair is the unreduced P2 shifted down alongside b.
	always_comb begin
		ms_wide  = {mult_q, {FW{1'b0}}} >> r_q;
		ms_a     = ms_wide[WW-1:FW];
		ms_b0    = {1'b0, ms_wide[FW-1:0]};
		pll_a    = div_quo[cdpc_pkg::QW-1:cdpc_pkg::FB_W];
		// round half up: b = (q + 1) / 2 with one extra fraction bit in q
		pll_q1   = {1'b0, div_quo[cdpc_pkg::FB_W-1:0]} + 1'b1;
		pll_b0   = pll_q1[cdpc_pkg::FB_W:1];
		ms_p1_n  = cdpc_pkg::MS_P1_W'({ms_a, {cdpc_pkg::P1_SHIFT{1'b0}}})
		         + cdpc_pkg::MS_P1_W'(ms_b0 >> (FW - cdpc_pkg::P1_SHIFT))
		         - cdpc_pkg::MS_P1_W'(cdpc_pkg::P1_OFFSET);
		pll_p1_n = cdpc_pkg::PLL_P1_W'({pll_a, {cdpc_pkg::P1_SHIFT{1'b0}}})
		         + cdpc_pkg::PLL_P1_W'(pll_b0 >> (FW - cdpc_pkg::P1_SHIFT))
		         - cdpc_pkg::PLL_P1_W'(cdpc_pkg::P1_OFFSET);
		ms_red   = (ms_c_q[cdpc_pkg::FB_W-1:1] != '0) && !ms_b_q[0];
		pll_red  = (pll_c_q[cdpc_pkg::FB_W-1:1] != '0) && !pll_b_q[0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			fout_q <= fout_in;
		end
		if (cmd.cap_mult) begin
			mult_q <= div_quo[cdpc_pkg::VCO_W-1:0] + 1'b1;
		end
		if (cmd.cap_fvco) begin
			fvco_q <= prod[cdpc_pkg::VCO_W-1:0];
		end
		if (cmd.cap_chk) begin
			r_q         <= r_sel;
			r_fit_q     <= r_fit;
			ratio_bad_q <= ratio_bad;
		end
		if (cmd.cap_words) begin
			ms_b_q   <= ms_b0;
			ms_c_q   <= cdpc_pkg::FB_W'(1) << FW;
			ms_p2_q  <= FW'({ms_b0, {cdpc_pkg::P1_SHIFT{1'b0}}});
			ms_p1_q  <= ms_p1_n;
			pll_b_q  <= pll_b0;
			pll_c_q  <= cdpc_pkg::FB_W'(1) << FW;
			pll_p2_q <= FW'({pll_b0, {cdpc_pkg::P1_SHIFT{1'b0}}});
			pll_p1_q <= pll_p1_n;
		end else if (cmd.red_step) begin
			if (ms_red) begin
				ms_b_q  <= ms_b_q >> 1;
				ms_c_q  <= ms_c_q >> 1;
				ms_p2_q <= ms_p2_q >> 1;
			end
			if (pll_red) begin
				pll_b_q  <= pll_b_q >> 1;
				pll_c_q  <= pll_c_q >> 1;
				pll_p2_q <= pll_p2_q >> 1;
			end
		end
	end

	always_comb begin
		if (freq_bad) begin
			status_n = cdpc_pkg::ST_FREQ;
		end else if (!r_fit_q) begin
			status_n = cdpc_pkg::ST_NO_R;
		end else if (ratio_bad_q) begin
			status_n = cdpc_pkg::ST_RATIO;
		end else begin
			status_n = cdpc_pkg::ST_OK;
		end
	end

	// Output register, zeroed words on any error
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_status_q <= status_n;
			if (status_n == cdpc_pkg::ST_OK) begin
				out_ms_p1_q  <= ms_p1_q;
				out_ms_p2_q  <= cdpc_pkg::MS_P2_W'(ms_p2_q);
				out_ms_p3_q  <= cdpc_pkg::P3_W'(ms_c_q);
				out_r_q      <= r_q;
				out_pll_p1_q <= pll_p1_q;
				out_pll_p2_q <= cdpc_pkg::PLL_P2_W'(pll_p2_q);
				out_pll_p3_q <= cdpc_pkg::P3_W'(pll_c_q);
			end else begin
				out_ms_p1_q  <= '0;
				out_ms_p2_q  <= '0;
				out_ms_p3_q  <= '0;
				out_r_q      <= '0;
				out_pll_p1_q <= '0;
				out_pll_p2_q <= '0;
				out_pll_p3_q <= '0;
			end
		end
	end

	always_comb begin
		sts.freq_bad  = freq_bad;
		sts.r_fit     = r_fit_q;
		sts.ratio_bad = ratio_bad_q;
		sts.div_done  = div_done;
		sts.red_done  = !ms_red && !pll_red;
	end

	assign ms_p1  = out_ms_p1_q;
	assign ms_p2  = out_ms_p2_q;
	assign ms_p3  = out_ms_p3_q;
	assign r_code = out_r_q;
	assign pll_p1 = out_pll_p1_q;
	assign pll_p2 = out_pll_p2_q;
	assign pll_p3 = out_pll_p3_q;
	assign status = out_status_q;

endmodule

// ===== src/cdpc_ctrl.sv =====
module cdpc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	input  cdpc_pkg::sts_t  sts,
	output cdpc_pkg::cmd_t  cmd
);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_DIVM   = 9'b000000010,
		S_WAITM  = 9'b000000100,
		S_MUL    = 9'b000001000,
		S_CHK    = 9'b000010000,
		S_DECIDE = 9'b000100000,
		S_WAITP  = 9'b001000000,
		S_RED    = 9'b010000000,
		S_DONE   = 9'b100000000
	} state_t;

	state_t state_q, state_n;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign accept   = in_valid && (state_q == S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_n = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.load_in = 1'b1;
					state_n     = S_DIVM;
				end
			end
			S_DIVM: begin
				if (sts.freq_bad) begin
					state_n = S_DONE;
				end else begin
					cmd.div_start = 1'b1;
					state_n       = S_WAITM;
				end
			end
			S_WAITM: begin
				if (sts.div_done) begin
					cmd.cap_mult = 1'b1;
					state_n      = S_MUL;
				end
			end
			S_MUL: begin
				cmd.cap_fvco = 1'b1;
				state_n      = S_CHK;
			end
			S_CHK: begin
				cmd.cap_chk = 1'b1;
				state_n     = S_DECIDE;
			end
			S_DECIDE: begin
				if (!sts.r_fit || sts.ratio_bad) begin
					state_n = S_DONE;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_pll   = 1'b1;
					state_n       = S_WAITP;
				end
			end
			S_WAITP: begin
				cmd.div_pll = 1'b1;
				if (sts.div_done) begin
					cmd.cap_words = 1'b1;
					state_n       = S_RED;
				end
			end
			S_RED: begin
				cmd.red_step = 1'b1;
				if (sts.red_done) begin
					state_n = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_n      = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == S_DIVM)
		else $error("accepted transaction did not start the sequence");

endmodule
